// ----- design/chst_pkg.sv -----
// ----------------------------------------------------------------------------
// chst_pkg
// Shared types and constants of the chained hash symbol table.
// ----------------------------------------------------------------------------
package chst_pkg;

  localparam int unsigned MaxEntriesDefault  = 4096;
  localparam int unsigned BucketCountDefault = 1024;
  localparam int unsigned NameSlotDefault    = 32;

  localparam int unsigned StatusW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned IndexW  = 12;
  localparam int unsigned HashW   = 16;

  typedef enum logic [StatusW-1:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef struct packed {
    logic func;
    logic [7:0] char_code;
    logic last_char;
    logic signed [ValueW-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    status_e status;
    logic signed [ValueW-1:0] symbol_value;
    logic [IndexW-1:0] entry_index;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take_char;     // buffer char, update hash
    logic clr_key;       // reset key buffer, length, hash
    logic clr_step;      // clear sweep / compare index
    logic inc_step;
    logic rd_head;       // read bucket head
    logic load_cur_head; // cur <= head read data
    logic rd_entry;      // read length, link, value of cur
    logic rd_char;       // read name char at cur/step
    logic load_cur_link; // cur <= link
    logic wr_char;       // write key char step into new entry
    logic wr_entry;      // write link, length, value, head
    logic clr_head;      // clear head at step
    logic out_load;      // latch result
    status_e out_status;
    logic out_use_new;   // result index/value from new entry
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic too_long;
    logic cur_zero;
    logic len_match;
    logic char_match;
    logic step_at_len;   // step == key length
    logic sweep_done;
    logic full;
  } sts_t;

endpackage

// ----- design/chst_if.sv -----
// ----------------------------------------------------------------------------
// chst_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface chst_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/chst_ram.sv -----
// ----------------------------------------------------------------------------
// chst_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module chst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- design/chst_datapath.sv -----
// ----------------------------------------------------------------------------
// chst_datapath
// Key buffer, hash, stores and chain walk registers of the symbol table.
// ----------------------------------------------------------------------------
module chst_datapath import chst_pkg::*; #(
  parameter int unsigned MaxEntries  = MaxEntriesDefault,
  parameter int unsigned BucketCount = BucketCountDefault,
  parameter int unsigned NameSlot    = NameSlotDefault,
  localparam int unsigned EntW  = $clog2(MaxEntries),
  localparam int unsigned FreeW = $clog2(MaxEntries + 1),
  localparam int unsigned BktW  = (BucketCount > 1) ? $clog2(BucketCount) : 1,
  localparam int unsigned SlotW = $clog2(NameSlot),
  localparam int unsigned LenW  = $clog2(NameSlot + 1),
  localparam int unsigned StepW = (BktW > LenW) ? BktW + 1 : LenW + 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output out_item_t out_o
);
  localparam logic [BktW:0] BktLim = (BktW + 1)'(BucketCount);

  logic [7:0]       key_q [NameSlot];
  logic [LenW-1:0]  len_q;
  logic [HashW-1:0] hash_q;
  logic [FreeW-1:0] free_q;
  logic [EntW-1:0]  cur_q;
  logic [StepW-1:0] step_q;
  logic             func_q;
  logic signed [ValueW-1:0] val_q;
  logic [BktW-1:0]  bkt;
  logic [BktW-1:0]  bkt_raw;
  logic [EntW-1:0]  head_rd, link_rd;
  logic [LenW-1:0]  nlen_rd;
  logic [ValueW-1:0] sval_rd;
  logic [7:0]       char_rd;
  logic [SlotW-1:0] step_slot;
  logic [EntW+SlotW-1:0] char_raddr, char_waddr;
  logic [EntW-1:0]  new_ent;
  logic [HashW-1:0] hash_next;
  out_item_t        out_q;

  // bucket: low hash bits folded into range
  assign bkt_raw = hash_q[BktW-1:0];
  assign bkt = ({1'b0, bkt_raw} >= BktLim) ? BktW'(bkt_raw - BktLim[BktW-1:0]) : bkt_raw;
  assign step_slot = step_q[SlotW-1:0];
  assign new_ent = free_q[EntW-1:0];
  assign hash_next = HashW'((hash_q << 5) - hash_q + HashW'(in_i.char_code));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      hash_q <= '0;
      free_q <= FreeW'(1);
      step_q <= '0;
    end else begin
      if (cmd_i.clr_key) begin
        len_q  <= '0;
        hash_q <= '0;
      end else if (cmd_i.take_char) begin
        if (len_q < LenW'(NameSlot)) len_q <= len_q + LenW'(1);
        hash_q <= hash_next;
      end
      if (cmd_i.clr_step) step_q <= '0;
      else if (cmd_i.inc_step) step_q <= step_q + StepW'(1);
      if (cmd_i.wr_entry) free_q <= free_q + FreeW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_char) begin
      if (len_q < LenW'(NameSlot)) key_q[len_q[SlotW-1:0]] <= in_i.char_code;
      func_q <= in_i.func;
      val_q  <= in_i.new_value;
    end
    if (cmd_i.load_cur_head) cur_q <= head_rd;
    else if (cmd_i.load_cur_link) cur_q <= link_rd;
    if (cmd_i.out_load) begin
      out_q.status <= cmd_i.out_status;
      if (cmd_i.out_status == ST_FOUND || cmd_i.out_status == ST_DUPLICATE) begin
        out_q.symbol_value <= sval_rd;
        out_q.entry_index  <= IndexW'(cur_q);
      end else if (cmd_i.out_use_new) begin
        out_q.symbol_value <= val_q;
        out_q.entry_index  <= IndexW'(new_ent);
      end else begin
        out_q.symbol_value <= '0;
        out_q.entry_index  <= '0;
      end
    end
  end

  chst_ram #(.Width(EntW), .Depth(BucketCount)) u_heads (
    .clk_i, .we_i(cmd_i.wr_entry || cmd_i.clr_head),
    .waddr_i(cmd_i.clr_head ? step_q[BktW-1:0] : bkt),
    .wdata_i(cmd_i.clr_head ? '0 : new_ent),
    .re_i(cmd_i.rd_head), .raddr_i(bkt), .rdata_o(head_rd)
  );
  chst_ram #(.Width(EntW), .Depth(MaxEntries)) u_links (
    .clk_i, .we_i(cmd_i.wr_entry), .waddr_i(new_ent), .wdata_i(head_rd),
    .re_i(cmd_i.rd_entry), .raddr_i(cur_q), .rdata_o(link_rd)
  );
  chst_ram #(.Width(LenW), .Depth(MaxEntries)) u_lens (
    .clk_i, .we_i(cmd_i.wr_entry), .waddr_i(new_ent), .wdata_i(len_q),
    .re_i(cmd_i.rd_entry), .raddr_i(cur_q), .rdata_o(nlen_rd)
  );
  chst_ram #(.Width(ValueW), .Depth(MaxEntries)) u_vals (
    .clk_i, .we_i(cmd_i.wr_entry), .waddr_i(new_ent), .wdata_i(val_q),
    .re_i(cmd_i.rd_entry), .raddr_i(cur_q), .rdata_o(sval_rd)
  );

  assign char_raddr = {cur_q, step_slot};
  assign char_waddr = {new_ent, step_slot};
  chst_ram #(.Width(8), .Depth(MaxEntries * (2 ** SlotW))) u_chars (
    .clk_i, .we_i(cmd_i.wr_char), .waddr_i(char_waddr), .wdata_i(key_q[step_slot]),
    .re_i(cmd_i.rd_char), .raddr_i(char_raddr), .rdata_o(char_rd)
  );

  // char_rd holds the char at step-1 when compared
  logic [SlotW-1:0] cmp_slot_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_char) cmp_slot_q <= step_slot;
  end

  always_comb begin
    sts_o.too_long    = (len_q > LenW'(NameSlot - 1));
    sts_o.cur_zero    = (cur_q == '0);
    sts_o.len_match   = (nlen_rd == len_q);
    sts_o.char_match  = (char_rd == key_q[cmp_slot_q]);
    sts_o.step_at_len = (step_q == StepW'(len_q));
    sts_o.sweep_done  = (step_q == StepW'(BucketCount - 1));
    sts_o.full        = (free_q >= FreeW'(MaxEntries));
    out_o             = out_q;
    if (!func_q) sts_o.full = 1'b0;
  end
endmodule

// ----- design/chst_ctrl.sv -----
// ----------------------------------------------------------------------------
// chst_ctrl
// Controller of the symbol table: handshake, clearing pass and chain walk.
// ----------------------------------------------------------------------------
module chst_ctrl import chst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  input  logic in_func_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_HEAD = 4'd2,
                         S_HEADW = 4'd3, S_ENT = 4'd4, S_ENTW = 4'd5,
                         S_CHR = 4'd6, S_CHRW = 4'd7, S_NEXT = 4'd8,
                         S_INS = 4'd9, S_DONE = 4'd10;

  logic [3:0] state_q, state_d;
  logic       func_q, func_d;
  logic       ovalid_q, ovalid_d;
  logic       acc;

  assign in_ready_o  = (state_q == S_IDLE) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.out_status = ST_FOUND;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_head = 1'b1;
        cmd_o.inc_step = 1'b1;
        if (sts_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          cmd_o.take_char = 1'b1;
          if (in_last_i) begin
            func_d  = in_func_i;
            state_d = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (sts_i.too_long) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_status = ST_TOO_LONG;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d = S_HEADW;
        end
      end
      S_HEADW: begin
        cmd_o.load_cur_head = 1'b1;
        state_d = S_ENT;
      end
      S_ENT: begin
        if (sts_i.cur_zero) begin
          state_d = S_INS;
        end else begin
          cmd_o.rd_entry = 1'b1;
          cmd_o.clr_step = 1'b1;
          state_d = S_ENTW;
        end
      end
      S_ENTW: begin
        state_d = sts_i.len_match ? S_CHR : S_NEXT;
      end
      S_CHR: begin
        if (sts_i.step_at_len) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_status = func_q ? ST_DUPLICATE : ST_FOUND;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_char = 1'b1;
          cmd_o.inc_step = 1'b1;
          state_d = S_CHRW;
        end
      end
      S_CHRW: begin
        state_d = sts_i.char_match ? S_CHR : S_NEXT;
      end
      S_NEXT: begin
        cmd_o.load_cur_link = 1'b1;
        state_d = S_ENT;
      end
      S_INS: begin
        if (!func_q) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_status = ST_NOT_FOUND;
          state_d = S_DONE;
        end else if (sts_i.full) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_status = ST_FULL;
          state_d = S_DONE;
        end else if (!sts_i.step_at_len) begin
          cmd_o.wr_char = 1'b1;
          cmd_o.inc_step = 1'b1;
        end else begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_use_new = 1'b1;
          cmd_o.out_status = ST_INSERTED;
          cmd_o.wr_entry = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.clr_key = 1'b1;
        ovalid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_ENT && sts_i.cur_zero) cmd_o.clr_step = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      func_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      func_q   <= func_d;
      ovalid_q <= ovalid_d;
    end
  end
endmodule

// ----- design/chained_hash_symbol_table.sv -----
// ----------------------------------------------------------------------------
// chained_hash_symbol_table
// Symbol table for short string keys, hashed buckets with chained entries.
//
// Usage:
//   in_if  (sink):   one key character per item, last_char closes the key;
//                    func and new_value are taken from the last character.
//   out_if (source): one result item per key: status, value, entry index.
//   A non-final character is taken while the controller is idle. A final
//   character starts a bucket head read and a chain walk: each entry has
//   its length, link and value read, an entry of equal length has its chars
//   compared one by one, and an insert writes the key chars, then the entry.
//   The chain walk over the registered-read stores sets the rate.
//   The result sits in an output register; no new item is taken until it is
//   delivered, so a stalled receiver holds the input side.
//   After reset a clearing pass writes every bucket head to empty, one per
//   cycle, during which no item is accepted.
// ----------------------------------------------------------------------------
module chained_hash_symbol_table import chst_pkg::*; #(
  parameter int unsigned MAX_ENTRIES  = MaxEntriesDefault,
  parameter int unsigned BUCKET_COUNT = BucketCountDefault,
  parameter int unsigned NAME_SLOT    = NameSlotDefault
) (
  input logic clk_i,
  input logic rst_ni,
  chst_if.sink   in_if,
  chst_if.source out_if
);
  cmd_t cmd;
  sts_t sts;
  in_item_t in_data;

  assign in_data = in_if.data;

  chst_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_last_i(in_data.last_char),
    .in_func_i(in_data.func), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  chst_datapath #(
    .MaxEntries(MAX_ENTRIES), .BucketCount(BUCKET_COUNT), .NameSlot(NAME_SLOT)
  ) u_dp (
    .clk_i, .rst_ni, .in_i(in_data), .cmd_i(cmd), .sts_o(sts),
    .out_o(out_if.data)
  );
endmodule

// ----- design/chst_checker.sv -----
// ----------------------------------------------------------------------------
// chst_checker
// Port-level checks of the symbol table.
// ----------------------------------------------------------------------------
module chst_checker import chst_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped");
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == ST_NOT_FOUND || out_data_i.status == ST_TOO_LONG
    || out_data_i.status == ST_FULL) |-> out_data_i.entry_index == '0)
    else $error("index on miss");
  a_hit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == ST_FOUND || out_data_i.status == ST_INSERTED)
    |-> out_data_i.entry_index != '0) else $error("entry zero used");
endmodule

bind chained_hash_symbol_table chst_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data)
);

// ----- tb/sv/chained_hash_symbol_table_test.sv -----
// ----------------------------------------------------------------------------
// chained_hash_symbol_table_test
// Drives keys one character per item into the symbol table and checks every
// result against a behavioral model of the buckets, chains and store kept in
// the testbench. Covers lookups, inserts, duplicates, over-long keys, bucket
// collisions and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chained_hash_symbol_table_test;
  import chst_pkg::*;

  localparam int unsigned Entries = MaxEntriesDefault;
  localparam int unsigned Buckets = BucketCountDefault;
  localparam int unsigned Slot    = NameSlotDefault;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  chst_if #(.T(in_item_t))  in_if ();
  chst_if #(.T(out_item_t)) out_if ();

  chained_hash_symbol_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [IndexW-1:0] head_tab [Buckets];
  logic [IndexW-1:0] link_tab [Entries];
  logic [7:0]        name_tab [Entries][Slot];
  int unsigned       len_tab  [Entries];
  logic [ValueW-1:0] val_tab  [Entries];
  int unsigned       free_entry;
  logic [7:0]        key_chars [Slot];
  int unsigned       key_len;
  logic [HashW-1:0]  hash_acc;

  out_item_t   pending_results [$];
  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_items;
  int unsigned status_seen [6];
  bit          noisy_send;
  bit          noisy_recv;
  bit          hold_on = 1'b0;
  int unsigned recv_idle;
  string       known_keys [$];

  function automatic void table_clear();
    foreach (head_tab[i]) head_tab[i] = '0;
    free_entry = 1;
    key_len = 0;
    hash_acc = '0;
  endfunction

  function automatic void table_apply(in_item_t it);
    int unsigned b;
    int unsigned k;
    int unsigned steps;
    bit hit;
    bit same;
    out_item_t r;
    if (key_len < Slot) begin
      key_chars[key_len] = it.char_code;
      key_len++;
    end
    hash_acc = hash_acc * 16'd31 + 16'(it.char_code);
    if (!it.last_char) return;
    r = '0;
    hit = 1'b0;
    if (key_len > Slot - 1) begin
      r.status = ST_TOO_LONG;
    end else begin
      b = hash_acc % Buckets;
      k = head_tab[b];
      steps = 0;
      while (k != 0 && steps < Entries && !hit) begin
        same = (len_tab[k] == key_len);
        for (int i = 0; i < key_len && same; i++)
          if (name_tab[k][i] != key_chars[i]) same = 1'b0;
        if (same) hit = 1'b1;
        else begin
          k = link_tab[k];
          steps++;
        end
      end
      if (hit) begin
        r.status = it.func ? ST_DUPLICATE : ST_FOUND;
        r.symbol_value = val_tab[k];
        r.entry_index = k[IndexW-1:0];
      end else if (!it.func) begin
        r.status = ST_NOT_FOUND;
      end else if (free_entry >= Entries) begin
        r.status = ST_FULL;
      end else begin
        k = free_entry;
        link_tab[k] = head_tab[b];
        head_tab[b] = k[IndexW-1:0];
        for (int i = 0; i < key_len; i++) name_tab[k][i] = key_chars[i];
        len_tab[k] = key_len;
        val_tab[k] = it.new_value;
        free_entry++;
        r.status = ST_INSERTED;
        r.symbol_value = it.new_value;
        r.entry_index = k[IndexW-1:0];
      end
    end
    pending_results.push_back(r);
    key_len = 0;
    hash_acc = '0;
  endfunction

  task automatic send_char(logic func, logic [7:0] ch, logic last, logic [ValueW-1:0] v);
    in_item_t it;
    int unsigned gap;
    if (noisy_send && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.func = func;
    it.char_code = ch;
    it.last_char = last;
    it.new_value = v;
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    table_apply(it);
    n_items++;
  endtask

  task automatic send_key(string s, logic func, logic [ValueW-1:0] v);
    for (int i = 0; i < s.len(); i++)
      send_char(func, s[i], i == s.len() - 1, v);
  endtask

  function automatic string rand_key(int unsigned lo, int unsigned hi);
    string s;
    int unsigned n;
    s = "";
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(1, 255)))};
    return s;
  endfunction

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // result side
  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_idle <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        n_results++;
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_results.pop_front();
          if (int'(want.status) < 6) status_seen[want.status]++;
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: expected st=%0d val=%0d idx=%0d got st=%0d val=%0d idx=%0d",
                       want.status, want.symbol_value, want.entry_index,
                       got.status, got.symbol_value, got.entry_index);
          end
        end
      end
      if (hold_on) begin
        out_if.ready <= 1'b0;
      end else if (recv_idle != 0) begin
        recv_idle <= recv_idle - 1;
        out_if.ready <= 1'b0;
      end else if (noisy_recv && $urandom_range(0, 3) == 0) begin
        recv_idle <= $urandom_range(0, 6);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    string k;
    send_key("a", 1'b0, 32'd5);
    send_key("a", 1'b1, 32'h7FFF_FFFF);
    send_key("a", 1'b0, 32'd0);
    send_key("a", 1'b1, 32'h8000_0000);
    send_char(1'b1, 8'h00, 1'b1, 32'hFFFF_FFFF);
    send_char(1'b1, 8'hFF, 1'b1, 32'd1);
    send_char(1'b0, 8'h00, 1'b1, 32'd0);
    // keys "\x01\x00" and "\x00\x1f" share a hash
    send_char(1'b1, 8'h01, 1'b0, 32'd11);
    send_char(1'b1, 8'h00, 1'b1, 32'd11);
    send_char(1'b1, 8'h00, 1'b0, 32'd12);
    send_char(1'b1, 8'h1F, 1'b1, 32'd12);
    send_char(1'b0, 8'h01, 1'b0, 32'd0);
    send_char(1'b0, 8'h00, 1'b1, 32'd0);
    send_char(1'b0, 8'h00, 1'b0, 32'd0);
    send_char(1'b0, 8'h1F, 1'b1, 32'd0);
    k = rand_key(Slot - 1, Slot - 1);
    send_key(k, 1'b1, 32'h1234_5678);
    send_key(k, 1'b0, 32'd0);
    send_key(rand_key(Slot, Slot), 1'b1, 32'd3);
    send_key(rand_key(Slot + 5, Slot + 5), 1'b0, 32'd3);
    wait_drained();
  endtask

  task automatic test_random(int unsigned n_keys);
    string k;
    int unsigned pick;
    for (int n = 0; n < n_keys; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4 && known_keys.size() != 0)
        k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      else if (pick == 9)
        k = rand_key(Slot - 2, Slot + 3);
      else
        k = rand_key(1, 6);
      if (k.len() < Slot && pick >= 4) known_keys.push_back(k);
      send_key(k, 1'($urandom_range(0, 1)), $urandom());
    end
  endtask

  task automatic test_output_stall();
    noisy_send = 1'b0;
    fork
      begin
        hold_on = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_on = 1'b0;
      end
    join_none
    test_random(10);
    wait_drained();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    n_errors = 0;
    n_results = 0;
    n_items = 0;
    noisy_send = 1'b0;
    noisy_recv = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    table_clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    noisy_send = 1'b1;
    noisy_recv = 1'b1;
    test_random(50);
    wait_drained();
    test_output_stall();
    noisy_send = 1'b1;
    noisy_recv = 1'b1;
    test_random(30);
    noisy_send = 1'b0;
    noisy_recv = 1'b0;
    test_random(20);
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("%0d characters sent, %0d results checked, %0d entries stored",
             n_items, n_results, free_entry - 1);
    $display("status counts: found %0d, absent %0d, inserted %0d, dup %0d, long %0d, full %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("chained_hash_symbol_table_test: PASS");
    end else begin
      $display("%0d errors, %0d results missing", n_errors, pending_results.size());
      $display("chained_hash_symbol_table_test: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("chained_hash_symbol_table_test: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
design/chst_pkg.sv
design/chst_if.sv
design/chst_ram.sv
design/chst_datapath.sv
design/chst_ctrl.sv
design/chained_hash_symbol_table.sv
design/chst_checker.sv
tb/sv/chained_hash_symbol_table_test.sv
